[rtl/gppd_pkg.sv]
`default_nettype none

package gppd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_ID    = 4'd2,
        PH_MARK  = 4'd3,
        PH_BTN1  = 4'd4,
        PH_BTN2  = 4'd5,
        PH_AX0   = 4'd6,
        PH_AX1   = 4'd7,
        PH_AX2   = 4'd8,
        PH_AX3   = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_DIGITAL = 2'd1,
        KIND_RED     = 2'd2,
        KIND_GREEN   = 2'd3
    } t_kind;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [1:0] CFG_ID_DIGITAL = 2'd0;
    localparam logic [1:0] CFG_ID_RED     = 2'd1;
    localparam logic [1:0] CFG_ID_GREEN   = 2'd2;

    localparam logic [7:0] RST_ID_DIGITAL = 8'd65;
    localparam logic [7:0] RST_ID_RED     = 8'd115;
    localparam logic [7:0] RST_ID_GREEN   = 8'd83;

    localparam logic [7:0] CMD_POLL_START = 8'h01;
    localparam logic [7:0] CMD_READ_DATA  = 8'h42;
    localparam logic [7:0] CMD_FILL       = 8'hff;
    localparam logic [7:0] CMD_NONE       = 8'h00;
    localparam logic [7:0] DATA_MARKER    = 8'h5a;

    localparam logic signed [7:0] AXIS_POS  = 8'sd127;
    localparam logic signed [7:0] AXIS_NEG  = -8'sd127;
    localparam logic [7:0]        AXIS_BIAS = 8'h80;

    localparam logic [3:0] HAT_CENTRE = 4'd8;

    typedef struct packed {
        logic [7:0] id_digital;
        logic [7:0] id_red;
        logic [7:0] id_green;
    } t_cfg_ids;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        face;
        logic [3:0]        system;
        logic [3:0]        hat;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
    } t_report;

    typedef struct packed {
        logic       finished;
        logic [7:0] command_byte;
        logic       attention_active;
        t_report    report;
    } t_result;

    // Pressed d-pad nibble (up, right, down, left in bits 0-3) to hat code.
    function automatic logic [3:0] hat_lookup(input logic [3:0] dpad);
        logic [3:0] hat;
        case (dpad)
            4'd1:    hat = 4'd0;
            4'd2:    hat = 4'd2;
            4'd3:    hat = 4'd1;
            4'd4:    hat = 4'd4;
            4'd6:    hat = 4'd3;
            4'd8:    hat = 4'd6;
            4'd9:    hat = 4'd7;
            4'd12:   hat = 4'd5;
            default: hat = HAT_CENTRE;
        endcase
        return hat;
    endfunction

endpackage

`default_nettype wire

[rtl/gppd_cfg_regs.sv]
`default_nettype none

module gppd_cfg_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data,
    output gppd_pkg::t_cfg_ids       o_ids
);
    import gppd_pkg::*;

    t_cfg_ids r_ids;
    t_cfg_ids n_ids;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_ids = r_ids;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ID_DIGITAL: n_ids.id_digital = i_cfg_data;
                CFG_ID_RED:     n_ids.id_red     = i_cfg_data;
                CFG_ID_GREEN:   n_ids.id_green   = i_cfg_data;
                default:        n_ids            = r_ids;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids.id_digital <= RST_ID_DIGITAL;
            r_ids.id_red     <= RST_ID_RED;
            r_ids.id_green   <= RST_ID_GREEN;
        end else begin
            r_ids <= n_ids;
        end
    end

    assign o_ids = r_ids;

endmodule

`default_nettype wire

[rtl/gppd_seq.sv]
`default_nettype none

module gppd_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_operation,
    input  wire logic [7:0]          i_rx_byte,
    input  wire logic                i_ack_seen,
    input  wire gppd_pkg::t_cfg_ids  i_ids,
    output gppd_pkg::t_result        o_result
);
    import gppd_pkg::*;

    t_phase  r_phase;
    t_phase  n_phase;
    t_report r_report;
    t_report n_report;
    t_report clear_report;
    t_kind   id_kind;
    logic    is_start;
    logic    done;
    logic    is_analog;
    logic [7:0] pressed;

    assign is_start  = (i_operation == OP_START);
    assign pressed   = ~i_rx_byte;
    assign is_analog = (r_report.kind == KIND_RED) || (r_report.kind == KIND_GREEN);

    // Digital wins over red, red over green when registers collide.
    always_comb begin
        if (i_rx_byte == i_ids.id_digital) begin
            id_kind = KIND_DIGITAL;
        end else if (i_rx_byte == i_ids.id_red) begin
            id_kind = KIND_RED;
        end else if (i_rx_byte == i_ids.id_green) begin
            id_kind = KIND_GREEN;
        end else begin
            id_kind = KIND_NONE;
        end
    end

    always_comb begin
        clear_report         = '0;
        clear_report.kind    = KIND_NONE;
        clear_report.hat     = HAT_CENTRE;
    end

    // Next phase.
    always_comb begin
        if (is_start) begin
            n_phase = PH_START;
        end else begin
            case (r_phase)
                PH_START: n_phase = i_ack_seen ? PH_ID : PH_IDLE;
                PH_ID:    n_phase = (id_kind != KIND_NONE) ? PH_MARK : PH_IDLE;
                PH_MARK:  n_phase = (i_rx_byte == DATA_MARKER) ? PH_BTN1 : PH_IDLE;
                PH_BTN1:  n_phase = PH_BTN2;
                PH_BTN2:  n_phase = is_analog ? PH_AX0 : PH_IDLE;
                PH_AX0:   n_phase = PH_AX1;
                PH_AX1:   n_phase = PH_AX2;
                PH_AX2:   n_phase = PH_AX3;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // Report update and command for this step.
    always_comb begin
        n_report = r_report;
        if (is_start) begin
            n_report = clear_report;
        end else begin
            case (r_phase)
                PH_ID: n_report.kind = id_kind;
                PH_BTN1: begin
                    if (pressed[0]) n_report.system[1] = 1'b1;
                    if (pressed[3]) n_report.system[0] = 1'b1;
                    if (r_report.kind == KIND_DIGITAL) begin
                        if (pressed[4]) n_report.left_y = AXIS_NEG;
                        if (pressed[6]) n_report.left_y = AXIS_POS;
                        if (pressed[7]) n_report.left_x = AXIS_NEG;
                        if (pressed[5]) n_report.left_x = AXIS_POS;
                    end else if (r_report.kind == KIND_RED) begin
                        if (pressed[1]) n_report.system[2] = 1'b1;
                        if (pressed[2]) n_report.system[3] = 1'b1;
                        n_report.hat = hat_lookup(pressed[7:4]);
                    end
                end
                PH_BTN2: n_report.face    = {pressed[3:0], pressed[7:4]};
                PH_AX0:  n_report.right_x = i_rx_byte ^ AXIS_BIAS;
                PH_AX1:  n_report.right_y = i_rx_byte ^ AXIS_BIAS;
                PH_AX2:  n_report.left_x  = i_rx_byte ^ AXIS_BIAS;
                PH_AX3:  n_report.left_y  = i_rx_byte ^ AXIS_BIAS;
                default: n_report = r_report;
            endcase
        end
    end

    assign done = (n_phase == PH_IDLE);

    always_comb begin
        o_result.finished         = done;
        o_result.attention_active = !done;
        o_result.report           = n_report;
        if (done) begin
            o_result.command_byte = CMD_NONE;
        end else if (is_start) begin
            o_result.command_byte = CMD_POLL_START;
        end else if (r_phase == PH_START) begin
            o_result.command_byte = CMD_READ_DATA;
        end else begin
            o_result.command_byte = CMD_FILL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_report <= clear_report;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_report <= n_report;
        end
    end

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_operation == OP_START) |=> (r_phase == PH_START))
        else $error("start step did not restart the poll");

    a_idle_byte_keeps_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_operation == OP_BYTE && r_phase == PH_IDLE) |=> $stable(r_report))
        else $error("byte while idle changed the report");

    a_axes_only_analog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_AX0 || r_phase == PH_AX3) |->
            (r_report.kind == KIND_RED || r_report.kind == KIND_GREEN))
        else $error("axis phase reached without an analog pad");

endmodule

`default_nettype wire

[rtl/game_pad_poll_decoder_unit.sv]
`default_nettype none

// Byte-level poll sequencer and report decoder for a game pad on a serial
// controller bus. An item with operation 0 starts a poll: the report is
// cleared and the block asks for command byte 0x01 with attention held low.
// Each later item reports one finished byte exchange from the serial engine;
// the result carries the next command byte (or finished, with attention
// released) and the full current report. The pad ID byte is matched against
// the three ID registers (digital first, then analog red, then analog green);
// an unknown ID, a missing ack after the first byte or a wrong 0x5a marker
// ends the poll. Items are taken one per clock cycle when the output is not
// blocked. Each item is held in the input register, decoded combinationally
// in a single short pass and written to the result register once that
// register is free or being emptied; the result is presented from there.
// Both channels use valid and stall, and an output register separates them
// so that a new item is taken while a result waits. The ID registers are
// written through a valid and ready port that is always ready; they are to
// be written only while no poll item is in flight, which the block itself
// does not enforce.
module game_pad_poll_decoder_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_ack_seen,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_finished,
    output logic [7:0]              o_command_byte,
    output logic                    o_attention_active,
    output logic [7:0]              o_face_buttons,
    output logic [3:0]              o_system_buttons,
    output logic [3:0]              o_hat_direction,
    output logic signed [7:0]       o_left_x,
    output logic signed [7:0]       o_left_y,
    output logic signed [7:0]       o_right_x,
    output logic signed [7:0]       o_right_y,
    output logic [1:0]              o_pad_kind
);
    import gppd_pkg::*;

    t_cfg_ids   ids;
    t_result    step_result;

    logic       r_in_valid;
    logic       r_in_operation;
    logic [7:0] r_in_rx_byte;
    logic       r_in_ack_seen;
    logic       r_out_valid;
    t_result    r_result;

    logic       in_take;
    logic       advance;

    // The held item moves on whenever the result register is empty or is
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    gppd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ids       (ids)
    );

    gppd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_operation (r_in_operation),
        .i_rx_byte   (r_in_rx_byte),
        .i_ack_seen  (r_in_ack_seen),
        .i_ids       (ids),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_operation <= i_operation;
            r_in_rx_byte   <= i_rx_byte;
            r_in_ack_seen  <= i_ack_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_finished         = r_result.finished;
    assign o_command_byte     = r_result.command_byte;
    assign o_attention_active = r_result.attention_active;
    assign o_face_buttons     = r_result.report.face;
    assign o_system_buttons   = r_result.report.system;
    assign o_hat_direction    = r_result.report.hat;
    assign o_left_x           = r_result.report.left_x;
    assign o_left_y           = r_result.report.left_y;
    assign o_right_x          = r_result.report.right_x;
    assign o_right_y          = r_result.report.right_y;
    assign o_pad_kind         = r_result.report.kind;

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with space in the pipeline");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[tb/sv/gppd_checker.sv]
module gppd_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,

    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic              i_operation,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_ack_seen,

    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic              i_finished,
    input  wire logic [7:0]        i_command_byte,
    input  wire logic              i_attention_active,
    input  wire logic [7:0]        i_face_buttons,
    input  wire logic [3:0]        i_system_buttons,
    input  wire logic [3:0]        i_hat_direction,
    input  wire logic signed [7:0] i_left_x,
    input  wire logic signed [7:0] i_left_y,
    input  wire logic signed [7:0] i_right_x,
    input  wire logic signed [7:0] i_right_y,
    input  wire logic [1:0]        i_pad_kind,

    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gppd_pkg::*;

    // Hat code for each pressed d-pad nibble (up, right, down, left in bits 0-3),
    // entry 15 first.
    localparam logic [63:0] HAT_BY_DPAD = {
        4'd8, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd7, 4'd6,
        4'd8, 4'd3, 4'd8, 4'd4, 4'd1, 4'd2, 4'd0, 4'd8
    };

    t_cfg_ids ids;
    t_phase   poll_phase;
    t_report  report;
    t_result  awaited_results[$];
    int       mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_report blank_report();
        t_report r;
        r      = '0;
        r.kind = KIND_NONE;
        r.hat  = HAT_CENTRE;
        return r;
    endfunction

    // Advances the poll by one item and returns the result it should produce.
    task automatic decode_exchange(input logic op, input logic [7:0] rx, input logic ack,
                                   output t_result res);
        logic [7:0] pressed;
        logic       poll_over;
        logic [7:0] next_cmd;
        pressed   = ~rx;
        poll_over = 1'b0;
        next_cmd  = CMD_FILL;
        if (op == OP_START) begin
            report     = blank_report();
            poll_phase = PH_START;
            next_cmd   = CMD_POLL_START;
        end else begin
            case (poll_phase)
                PH_START: begin
                    if (ack) begin
                        next_cmd   = CMD_READ_DATA;
                        poll_phase = PH_ID;
                    end else begin
                        poll_over = 1'b1;
                    end
                end
                PH_ID: begin
                    if (rx == ids.id_digital)    report.kind = KIND_DIGITAL;
                    else if (rx == ids.id_red)   report.kind = KIND_RED;
                    else if (rx == ids.id_green) report.kind = KIND_GREEN;
                    else                         report.kind = KIND_NONE;
                    if (report.kind == KIND_NONE) poll_over = 1'b1;
                    else poll_phase = PH_MARK;
                end
                PH_MARK: begin
                    if (rx == DATA_MARKER) poll_phase = PH_BTN1;
                    else poll_over = 1'b1;
                end
                PH_BTN1: begin
                    if (pressed[0]) report.system[1] = 1'b1;
                    if (pressed[3]) report.system[0] = 1'b1;
                    if (report.kind == KIND_DIGITAL) begin
                        // Down wins over up and right over left.
                        if (pressed[4]) report.left_y = AXIS_NEG;
                        if (pressed[6]) report.left_y = AXIS_POS;
                        if (pressed[7]) report.left_x = AXIS_NEG;
                        if (pressed[5]) report.left_x = AXIS_POS;
                    end else if (report.kind == KIND_RED) begin
                        if (pressed[1]) report.system[2] = 1'b1;
                        if (pressed[2]) report.system[3] = 1'b1;
                        report.hat = HAT_BY_DPAD[{pressed[7:4], 2'b00} +: 4];
                    end
                    poll_phase = PH_BTN2;
                end
                PH_BTN2: begin
                    report.face = {pressed[3:0], pressed[7:4]};
                    if (report.kind == KIND_RED || report.kind == KIND_GREEN) begin
                        poll_phase = PH_AX0;
                    end else begin
                        poll_over = 1'b1;
                    end
                end
                PH_AX0: begin
                    report.right_x = rx ^ AXIS_BIAS;
                    poll_phase     = PH_AX1;
                end
                PH_AX1: begin
                    report.right_y = rx ^ AXIS_BIAS;
                    poll_phase     = PH_AX2;
                end
                PH_AX2: begin
                    report.left_x = rx ^ AXIS_BIAS;
                    poll_phase    = PH_AX3;
                end
                PH_AX3: begin
                    report.left_y = rx ^ AXIS_BIAS;
                    poll_over     = 1'b1;
                end
                default: poll_over = 1'b1;
            endcase
            if (poll_over) poll_phase = PH_IDLE;
        end
        res.finished         = poll_over;
        res.command_byte     = poll_over ? CMD_NONE : next_cmd;
        res.attention_active = !poll_over;
        res.report           = report;
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ids        = {RST_ID_DIGITAL, RST_ID_RED, RST_ID_GREEN};
            poll_phase = PH_IDLE;
            report     = blank_report();
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ID_DIGITAL: ids.id_digital = i_cfg_data;
                    CFG_ID_RED:     ids.id_red     = i_cfg_data;
                    CFG_ID_GREEN:   ids.id_green   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                decode_exchange(i_operation, i_rx_byte, i_ack_seen, want);
                awaited_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result arrived with nothing expected", $time);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("finished", 8'(want.finished), 8'(i_finished));
                    compare_field("command_byte", want.command_byte, i_command_byte);
                    compare_field("attention_active", 8'(want.attention_active),
                                  8'(i_attention_active));
                    compare_field("face_buttons", want.report.face, i_face_buttons);
                    compare_field("system_buttons", 8'(want.report.system),
                                  8'(i_system_buttons));
                    compare_field("hat_direction", 8'(want.report.hat),
                                  8'(i_hat_direction));
                    compare_field("left_x", want.report.left_x, i_left_x);
                    compare_field("left_y", want.report.left_y, i_left_y);
                    compare_field("right_x", want.report.right_x, i_right_x);
                    compare_field("right_y", want.report.right_y, i_right_y);
                    compare_field("pad_kind", 8'(want.report.kind), 8'(i_pad_kind));
                end
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gppd_pkg::*;

    // Long hold-off of the result side, to fill the block and make it stall its input.
    localparam int HOLD_OFF_CYCLES   = 64;
    // Cycles without any accepted item before the run is declared hung.
    localparam int QUIET_LIMIT       = 2000;
    // Extra cycles after the results have drained, to cover any stragglers.
    localparam int SETTLE_CYCLES     = 8;
    localparam int ITEMS_PER_SEGMENT = 90;
    localparam int SEGMENTS          = 6;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;

    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index  = CFG_ID_DIGITAL;
    logic [7:0]        cfg_data   = 8'h00;

    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              operation  = OP_START;
    logic [7:0]        rx_byte    = 8'h00;
    logic              ack_seen   = 1'b0;

    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              finished;
    logic [7:0]        command_byte;
    logic              attention_active;
    logic [7:0]        face_buttons;
    logic [3:0]        system_buttons;
    logic [3:0]        hat_direction;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic [1:0]        pad_kind;

    int                fail_count;
    int                pending;

    // Idling odds in percent per cycle for each side, and the count of long hold-offs
    // asked of the result side so far.
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_requests = 0;
    int                items_sent    = 0;
    int                quiet_cycles  = 0;

    // The stimulus keeps its own copy of the pad IDs so that most polls carry an ID
    // that the block will recognise.
    t_cfg_ids          pad_ids = {RST_ID_DIGITAL, RST_ID_RED, RST_ID_GREEN};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    game_pad_poll_decoder_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_operation        (operation),
        .i_rx_byte          (rx_byte),
        .i_ack_seen         (ack_seen),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_finished         (finished),
        .o_command_byte     (command_byte),
        .o_attention_active (attention_active),
        .o_face_buttons     (face_buttons),
        .o_system_buttons   (system_buttons),
        .o_hat_direction    (hat_direction),
        .o_left_x           (left_x),
        .o_left_y           (left_y),
        .o_right_x          (right_x),
        .o_right_y          (right_y),
        .o_pad_kind         (pad_kind)
    );

    gppd_checker report_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_operation        (operation),
        .i_rx_byte          (rx_byte),
        .i_ack_seen         (ack_seen),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_finished         (finished),
        .i_command_byte     (command_byte),
        .i_attention_active (attention_active),
        .i_face_buttons     (face_buttons),
        .i_system_buttons   (system_buttons),
        .i_hat_direction    (hat_direction),
        .i_left_x           (left_x),
        .i_left_y           (left_y),
        .i_right_x          (right_x),
        .i_right_y          (right_y),
        .i_pad_kind         (pad_kind),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Result side. Each cycle it stalls at random with the current odds, unless the
    // stimulus has asked for a long hold-off, which this process times on its own
    // while the item side carries on offering polls.
    initial begin : result_side
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: any accepted item on any channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one item, after a random gap, and returns at the edge where it is taken.
    // Valid is left high, so the next item can follow without a bubble.
    task automatic send_item(input logic op, input logic [7:0] data, input logic ack);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= data;
        ack_seen  <= ack;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Withdraws the item side and waits until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Writes one ID register and returns at the edge where the write is taken.
    task automatic write_id(input logic [1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_ids(input logic [7:0] dig, input logic [7:0] red,
                            input logic [7:0] green);
        write_id(CFG_ID_DIGITAL, dig);
        write_id(CFG_ID_RED, red);
        write_id(CFG_ID_GREEN, green);
        cfg_valid <= 1'b0;
        pad_ids = {dig, red, green};
    endtask

    // One poll with random content. Most polls are well formed so that the button and
    // axis bytes are reached; a few carry a missing ack, an unknown ID or a bad marker,
    // some are cut short so that the next start lands mid-poll, and some run on into
    // exchanges that arrive while the block is idle.
    task automatic run_poll();
        int         roll;
        int         length;
        int         n;
        logic [7:0] pad_id;
        logic [7:0] data;
        roll = $urandom_range(99);
        if (roll < 30)      pad_id = pad_ids.id_digital;
        else if (roll < 60) pad_id = pad_ids.id_red;
        else if (roll < 88) pad_id = pad_ids.id_green;
        else                pad_id = 8'($urandom);
        // Exchanges after the ack byte: the ID, the marker, two button bytes and, for
        // analog pads, four axis bytes. Matching follows the block's own priority.
        if (pad_id == pad_ids.id_digital) begin
            length = 4;
        end else if (pad_id == pad_ids.id_red || pad_id == pad_ids.id_green) begin
            length = 8;
        end else begin
            length = 1;
        end
        roll = $urandom_range(99);
        if (roll < 8) begin
            length = $urandom_range(length - 1, 0);
        end else if (roll < 14) begin
            length = length + $urandom_range(2, 1);
        end
        send_item(OP_START, 8'($urandom), 1'($urandom));
        send_item(OP_BYTE, 8'($urandom), $urandom_range(99) < 92);
        for (n = 0; n < length; n++) begin
            if (n == 0) begin
                data = pad_id;
            end else if (n == 1 && $urandom_range(99) < 92) begin
                data = DATA_MARKER;
            end else begin
                data = 8'($urandom);
            end
            send_item(OP_BYTE, data, 1'($urandom));
        end
    endtask

    initial begin : stimulus
        int seg;
        int seg_end;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // An exchange with no poll running changes nothing and reports the reset state.
        send_item(OP_BYTE, 8'hc3, 1'b1);

        // Digital pad with every button pressed: down beats up, right beats left.
        // Acks after the first byte are dropped on purpose, as they must be ignored.
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hff, 1'b1);
        send_item(OP_BYTE, RST_ID_DIGITAL, 1'b0);
        send_item(OP_BYTE, DATA_MARKER, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b0);

        // Red analog pad with L3 and R3 held, an impossible d-pad pattern that gives a
        // centred hat, and the four axis bytes at their extremes and midpoints.
        send_item(OP_START, 8'hff, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, RST_ID_RED, 1'b1);
        send_item(OP_BYTE, DATA_MARKER, 1'b1);
        send_item(OP_BYTE, 8'h09, 1'b1);
        send_item(OP_BYTE, 8'hff, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'hff, 1'b1);
        send_item(OP_BYTE, 8'h80, 1'b1);
        send_item(OP_BYTE, 8'h7f, 1'b1);

        // No ack after the first command byte ends the poll with a cleared report.
        send_item(OP_START, 8'h5a, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b0);

        // An unrecognised pad ID ends the poll with no pad kind.
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);

        // A second start restarts the poll; a green pad then sends a wrong marker,
        // which ends the poll but keeps the pad kind.
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, RST_ID_GREEN, 1'b1);
        send_item(OP_BYTE, 8'ha5, 1'b1);

        // Random polls in segments. Each segment starts on a quiet block with new IDs,
        // colliding ones among them, and the idling pattern changes every two segments.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg)
                0:       load_ids(8'h00, 8'hff, 8'h80);
                1:       load_ids(8'h41, 8'h41, 8'h41);
                2:       load_ids(8'h12, 8'h73, 8'h73);
                3:       load_ids(8'hff, 8'h00, 8'h53);
                4:       load_ids(8'($urandom), 8'($urandom), 8'($urandom));
                default: load_ids(RST_ID_DIGITAL, RST_ID_RED, RST_ID_GREEN);
            endcase
            send_idle_pct <= (seg < 2) ? 7 : (seg < 4) ? 76 : 0;
            recv_idle_pct <= (seg < 2) ? 76 : (seg < 4) ? 7 : 0;
            // With neither side idling, a long hold-off lets the block back up fully.
            if (seg == SEGMENTS - 1) hold_requests <= hold_requests + 1;
            seg_end = items_sent + ITEMS_PER_SEGMENT;
            while (items_sent < seg_end) run_poll();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[game_pad_poll_decoder_unit.f]
rtl/gppd_pkg.sv
rtl/gppd_cfg_regs.sv
rtl/gppd_seq.sv
rtl/game_pad_poll_decoder_unit.sv
tb/sv/gppd_checker.sv
tb/sv/tb_top.sv
